/* sv/fam_pkg.sv */
// Shared types and constants of the frame average motion detector.
package fam_pkg;

  // Frame length is limited to this many bytes before the sampling window is formed.
  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  // Distance between sampled bytes; must be a power of two.
  localparam int unsigned SAMPLE_STRIDE   = 64;

  localparam int unsigned SUM_W   = 22;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 14'd16383;
  localparam logic [7:0]         EMPTY_AVERAGE = 8'd128;
  localparam logic [7:0]         RESET_THRESHOLD = 8'd15;
  localparam logic [31:0]        RESET_COOLDOWN  = 32'd5000;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_COOLDOWN  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [19:0] byte_position;
    logic [20:0] frame_length;
    logic        frame_end;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic       motion_flag;
    logic [7:0] frame_average;
    logic [7:0] average_change;
    logic       baseline_frame;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } samp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* sv/frame_average_motion_detector_core.sv */
// Top level of the frame average motion detector: sequencer, motion state and output register.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (fam_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (fam_pkg::out_item_t)
//   cfg      input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// A byte that does not end a frame is taken without a stall: it only updates the running
// sum and count. After a frame-end transfer the input stalls while the sequencer is in
// ST_DIV and ST_OUT: the restoring divider turns out one quotient bit per cycle, its
// registered done flag moves the sequencer to ST_OUT, and the commit step there, once the
// output register is free, updates the motion state and loads the output register with the result.
// Reset clears the sum, count, baseline, motion state and output valid, and loads the
// reset values of the threshold and cooldown registers.
// A waiting result does not block further non-final bytes; only the next frame end waits
// in its commit step until the output register is free.
module frame_average_motion_detector_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fam_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fam_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IN,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  logic                      in_accept;
  logic                      frame_done;
  fam_pkg::samp_t            tot;
  fam_pkg::div_status_t      div_status;
  logic [fam_pkg::SUM_W-1:0] quot;

  // Configuration registers.
  logic [7:0]  threshold_q, threshold_d;
  logic [31:0] cooldown_q, cooldown_d;

  // Detector state.
  logic [7:0]  prev_avg_q, prev_avg_d;
  logic        base_valid_q, base_valid_d;
  logic        motion_q, motion_d;
  logic [31:0] last_time_q, last_time_d;

  // Values captured with the frame-end byte.
  logic [31:0] time_q, time_d;
  logic        empty_q, empty_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  fam_pkg::out_item_t out_q, out_d;

  logic        out_free;
  logic [7:0]  avg;
  logic [7:0]  change;
  logic [31:0] elapsed;

  assign in_stall_o = (state_q != ST_IN);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign frame_done = in_accept && in_data_i.frame_end;
  assign out_free   = !out_valid_q || !out_stall_i;

  fam_sample_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .tot_o    (tot)
  );

  // The sum and count including the frame-end byte go straight into the divider.
  fam_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_done),
    .dividend_i (tot.sum),
    .divisor_i  (tot.count),
    .status_o   (div_status),
    .quot_o     (quot)
  );

  // The quotient never exceeds the largest byte value, so its low byte is the average.
  assign avg     = empty_q ? fam_pkg::EMPTY_AVERAGE : quot[7:0];
  assign change  = (avg >= prev_avg_q) ? (avg - prev_avg_q) : (prev_avg_q - avg);
  assign elapsed = time_q - last_time_q;

  always_comb begin
    state_d      = state_q;
    threshold_d  = threshold_q;
    cooldown_d   = cooldown_q;
    prev_avg_d   = prev_avg_q;
    base_valid_d = base_valid_q;
    motion_d     = motion_q;
    last_time_d  = last_time_q;
    time_d       = time_q;
    empty_d      = empty_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (cfg_we_i) begin
      unique case (fam_pkg::cfg_index_e'(cfg_index_i))
        fam_pkg::CFG_THRESHOLD: threshold_d = cfg_wdata_i[7:0];
        fam_pkg::CFG_COOLDOWN:  cooldown_d  = cfg_wdata_i;
        default:                threshold_d = threshold_q;
      endcase
    end

    unique case (state_q)
      ST_IN: begin
        if (frame_done) begin
          time_d  = in_data_i.time_ms;
          empty_d = (tot.count == '0);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.frame_average = avg;
          if (!base_valid_q) begin
            // The first frame after reset only records its average.
            base_valid_d         = 1'b1;
            out_d.average_change = '0;
            out_d.baseline_frame = 1'b1;
            out_d.motion_flag    = motion_q;
          end else begin
            out_d.average_change = change;
            out_d.baseline_frame = 1'b0;
            if (change > threshold_q) begin
              motion_d    = 1'b1;
              last_time_d = time_q;
            end else if (motion_q && (elapsed > cooldown_q)) begin
              motion_d = 1'b0;
            end
            out_d.motion_flag = (change > threshold_q) ? 1'b1 :
                                (motion_q && !(elapsed > cooldown_q));
          end
          prev_avg_d  = avg;
          out_valid_d = 1'b1;
          state_d     = ST_IN;
        end
      end
      default: state_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IN;
      threshold_q  <= fam_pkg::RESET_THRESHOLD;
      cooldown_q   <= fam_pkg::RESET_COOLDOWN;
      prev_avg_q   <= '0;
      base_valid_q <= 1'b0;
      motion_q     <= 1'b0;
      last_time_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      threshold_q  <= threshold_d;
      cooldown_q   <= cooldown_d;
      prev_avg_q   <= prev_avg_d;
      base_valid_q <= base_valid_d;
      motion_q     <= motion_d;
      last_time_q  <= last_time_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q  <= time_d;
    empty_q <= empty_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result appears only from the commit step of the sequencer.
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the commit step");

  // While the divider runs, no byte is taken in.
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.busy |-> in_stall_o)
    else $error("input taken while the divider is busy");

  // A frame-end transfer starts the divider.
  a_frame_end_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (state_q == ST_DIV) && div_status.busy)
    else $error("frame end did not start the division");

  // A baseline result reports no change and leaves the baseline set afterwards.
  a_baseline_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.baseline_frame) |-> (out_data_o.average_change == '0)
      && base_valid_q)
    else $error("baseline result is inconsistent");

endmodule

/* sv/fam_sample_acc.sv */
// Sampling window test and running sum and count of the sampled bytes.
module fam_sample_acc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  fam_pkg::in_item_t item_i,
  output fam_pkg::samp_t   tot_o
);

  localparam int unsigned StrideW = $clog2(fam_pkg::SAMPLE_STRIDE);

  logic [fam_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [fam_pkg::COUNT_W-1:0] count_q, count_d;
  logic [20:0] len;
  logic [18:0] lo;
  logic [22:0] len3;
  logic [20:0] hi;
  logic [19:0] offset;
  logic        in_window;
  logic        sampled;

  // Clamp the length, then form [L/4, 3L/4).
  assign len = (item_i.frame_length > 21'(fam_pkg::MAX_FRAME_BYTES)) ?
               21'(fam_pkg::MAX_FRAME_BYTES) : item_i.frame_length;
  assign lo   = len[20:2];
  assign len3 = {1'b0, len, 1'b0} + {2'b00, len};
  assign hi   = len3[22:2];
  assign offset = item_i.byte_position - {1'b0, lo};
  assign in_window = (item_i.byte_position >= {1'b0, lo}) &&
                     ({1'b0, item_i.byte_position} < hi);
  if (StrideW == 0) begin : g_every
    assign sampled = in_window;
  end else begin : g_stride
    assign sampled = in_window && (offset[StrideW-1:0] == '0);
  end

  always_comb begin
    tot_o.sum   = sum_q;
    tot_o.count = count_q;
    if (sampled && (count_q < fam_pkg::COUNT_MAX)) begin
      tot_o.sum   = sum_q + fam_pkg::SUM_W'(item_i.pixel_byte);
      tot_o.count = count_q + 1'b1;
    end
    sum_d   = sum_q;
    count_d = count_q;
    if (accept_i) begin
      if (item_i.frame_end) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = tot_o.sum;
        count_d = tot_o.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

/* sv/fam_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module fam_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fam_pkg::SUM_W-1:0]   dividend_i,
  input  logic [fam_pkg::COUNT_W-1:0] divisor_i,
  output fam_pkg::div_status_t        status_o,
  output logic [fam_pkg::SUM_W-1:0]   quot_o
);

  logic [fam_pkg::SUM_W-1:0]   work_q, work_d;
  logic [fam_pkg::COUNT_W-1:0] divisor_q, divisor_d;
  logic [fam_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [fam_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [fam_pkg::COUNT_W:0]   trial;
  logic [fam_pkg::COUNT_W+1:0] diff;

  // The remainder stays below the divisor, so it fits the divisor's width.
  assign trial = {rem_q, work_q[fam_pkg::SUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};

  always_comb begin
    work_d    = work_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    step_d    = step_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      work_d    = dividend_i;
      divisor_d = divisor_i;
      rem_d     = '0;
      step_d    = fam_pkg::STEP_W'(fam_pkg::DIV_STEPS - 1);
      busy_d    = 1'b1;
    end else if (busy_q) begin
      if (!diff[fam_pkg::COUNT_W+1]) begin
        rem_d  = diff[fam_pkg::COUNT_W-1:0];
        work_d = {work_q[fam_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[fam_pkg::COUNT_W-1:0];
        work_d = {work_q[fam_pkg::SUM_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = work_q;

endmodule
